[rtl/firmware_block_scrambler_assert.svh]
// assertion macros for the firmware block scrambler checker
// depends on clk and rst being visible where a macro is used
`ifndef FIRMWARE_BLOCK_SCRAMBLER_ASSERT_SVH
`define FIRMWARE_BLOCK_SCRAMBLER_ASSERT_SVH

// same-cycle implication, off during reset
`define FBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches reset itself
`define FBS_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fbs_pkg.sv]
// shared types and constants of the firmware block scrambler
// no dependencies
package fbs_pkg;

  localparam int BLK_LEN = 16;
  localparam int POS_W   = 4;
  localparam int ENC_OFS = 12;  // encode reads plaintext twelve places on, four back
  localparam int DEC_ROT = 4;   // decode emits the block rotated by four

  typedef logic [BLK_LEN-1:0][7:0] blk_bytes_t;

  // fixed block key, entry 0 in the low byte
  localparam blk_bytes_t KEY = {
    8'h61, 8'h74, 8'h73, 8'h4d, 8'h84, 8'h25, 8'h46, 8'ha3,
    8'h4e, 8'h35, 8'h6b, 8'h49, 8'h43, 8'hc4, 8'h36, 8'h7a
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_block;
    logic       segment_end;
    logic [7:0] segment_checksum;
  } out_req_t;

  // one finished block, bytes already in output order
  typedef struct packed {
    blk_bytes_t data;
    logic       seg_end;
    logic [7:0] checksum;
  } blk_entry_t;

endpackage

[rtl/fbs_front.sv]
// front part: takes request bytes, assembles blocks, chains and keys them
// depends on fbs_pkg
module fbs_front import fbs_pkg::*; #(
  parameter int BLOCKS_PER_SEGMENT = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_req,
  input  logic       q_full,
  output logic       push,
  output blk_entry_t push_entry
);

  localparam int CNT_W = (BLOCKS_PER_SEGMENT > 1) ? $clog2(BLOCKS_PER_SEGMENT) : 1;
  localparam logic [CNT_W-1:0] LAST_BLK = CNT_W'(BLOCKS_PER_SEGMENT - 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLK_LEN - 1);

  logic             dir;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] blk_cnt;
  logic [7:0]       run_sum;
  logic [7:0]       psum_enc;
  logic [7:0]       psum_dec;
  blk_bytes_t       chain;
  blk_bytes_t       fill;

  logic             accept;
  logic [POS_W-1:0] pos_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [7:0]       run_eff;
  logic [7:0]       psum_enc_eff;
  logic [7:0]       psum_dec_eff;
  blk_bytes_t       chain_eff;
  logic [7:0]       plain_dec;
  logic             last;
  blk_bytes_t       blk;
  blk_bytes_t       res;
  blk_bytes_t       newc;
  blk_bytes_t       emit;
  logic [7:0]       blk_sum;
  logic             seg_end;

  assign in_stall = q_full && (pos == LAST_POS);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_eff      = in_req.first ? '0 : pos;
    cnt_eff      = in_req.first ? '0 : blk_cnt;
    run_eff      = in_req.first ? '0 : run_sum;
    psum_enc_eff = in_req.first ? '0 : psum_enc;
    psum_dec_eff = in_req.first ? '0 : psum_dec;
    chain_eff    = in_req.first ? '0 : chain;
    // decoded plaintext of this byte; both partial sums run so the
    // direction only matters on the block's last byte
    plain_dec = in_req.data_byte ^ KEY[pos_eff] ^ chain_eff[pos_eff];
    last = (pos_eff == LAST_POS);
    blk = fill;
    blk[BLK_LEN-1] = in_req.data_byte;
    for (int i = 0; i < BLK_LEN; i++) begin
      if (dir) begin
        newc[i] = blk[POS_W'(i + ENC_OFS)] ^ chain_eff[i];
        res[i]  = newc[i] ^ KEY[i];
      end else begin
        newc[i] = blk[i] ^ KEY[i];
        res[i]  = newc[i] ^ chain_eff[i];
      end
    end
    for (int i = 0; i < BLK_LEN; i++) begin
      emit[i] = dir ? res[i] : res[POS_W'(i + DEC_ROT)];
    end
    blk_sum = run_eff + (dir ? (psum_enc_eff + in_req.data_byte)
                             : (psum_dec_eff + plain_dec));
    seg_end = (cnt_eff == LAST_BLK);
  end

  assign push                = accept && last;
  assign push_entry.data     = emit;
  assign push_entry.seg_end  = seg_end;
  assign push_entry.checksum = seg_end ? blk_sum : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir      <= 1'b0;
      pos      <= '0;
      blk_cnt  <= '0;
      run_sum  <= '0;
      psum_enc <= '0;
      psum_dec <= '0;
      chain    <= '0;
    end else begin
      if (cfg_we) begin
        dir <= cfg_wdata;
      end
      if (accept) begin
        pos <= pos_eff + POS_W'(1);
        if (last) begin
          psum_enc <= '0;
          psum_dec <= '0;
          chain    <= seg_end ? '0 : newc;
          blk_cnt  <= seg_end ? '0 : cnt_eff + CNT_W'(1);
          run_sum  <= seg_end ? '0 : blk_sum;
        end else begin
          psum_enc <= psum_enc_eff + in_req.data_byte;
          psum_dec <= psum_dec_eff + plain_dec;
          chain    <= chain_eff;
          blk_cnt  <= cnt_eff;
          run_sum  <= run_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fill[pos_eff] <= in_req.data_byte;
    end
  end

endmodule

[rtl/fbs_queue.sv]
// two-entry block queue between front and back
// depends on fbs_pkg
module fbs_queue import fbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  blk_entry_t push_entry,
  output logic       full,
  output logic       q_valid,
  output blk_entry_t head,
  input  logic       pop
);

  blk_entry_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/fbs_back.sv]
// back part: walks the head block one byte a cycle, unless stalled, into the output register
// depends on fbs_pkg
module fbs_back import fbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  blk_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_req_t   out_req
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLK_LEN - 1);

  logic [POS_W-1:0] idx;
  logic             load;
  logic             idx_last;

  assign load     = q_valid && (!out_valid || !out_stall);
  assign idx_last = (idx == LAST_POS);
  assign pop      = load && idx_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx + POS_W'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_req.out_byte         <= head.data[idx];
      out_req.last_of_block    <= idx_last;
      out_req.segment_end      <= head.seg_end;
      out_req.segment_checksum <= head.checksum;
    end
  end

endmodule

[rtl/firmware_block_scrambler.sv]
// a block's 16th input byte queues it; its first byte then enters the output register
// one byte per cycle in and out, sustained across blocks, while out_stall stays low
// the back part emits one stored block byte per unstalled cycle from the two-block queue
// rst is synchronous: direction back to decode, chain, position, counts and sums cleared
// depends on fbs_pkg, fbs_front, fbs_queue, fbs_back
module firmware_block_scrambler import fbs_pkg::*; #(
  parameter int BLOCKS_PER_SEGMENT = 32
) (
  input  logic     clk,
  input  logic     rst,
  // direction register, 0 decode and 1 encode
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  // input requests, one image byte each
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  // output requests, sixteen per finished block
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  // front to queue
  logic       push;
  blk_entry_t push_entry;
  logic       q_full;
  // queue to back
  logic       q_valid;
  blk_entry_t head;
  logic       pop;

  // byte assembly, chaining and keying of a whole block on its last byte;
  // the front only stalls while pos is at a block's last byte and both queue slots hold blocks
  fbs_front #(
    .BLOCKS_PER_SEGMENT(BLOCKS_PER_SEGMENT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  // double buffering of finished blocks so front and back stall apart
  fbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop)
  );

  // serialization through the output register
  fbs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

endmodule

[rtl/fbs_checker.sv]
// port-level checks of the firmware block scrambler, bound to the top level
// depends on fbs_pkg and firmware_block_scrambler_assert.svh
`include "firmware_block_scrambler_assert.svh"

module fbs_checker import fbs_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_req
);

  `FBS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_req), "stalled output request changed")
  `FBS_ASSERT_IMP(a_sum_zero, out_valid && !out_req.segment_end, out_req.segment_checksum == 8'd0, "checksum set outside a segment end")
  `FBS_ASSERT_IMP(a_stall_busy, in_stall, out_valid, "input stalled while output idle")
  `FBS_ASSERT_RST(a_rst_idle, rst, !out_valid && !in_stall, "not idle after reset")

endmodule

bind firmware_block_scrambler fbs_checker u_fbs_checker (.*);
